### sv/plst_pkg.sv
// Shared constants, codes and types of the positional list store.
`timescale 1ns / 1ps

package plst_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = 6;
    localparam int DEPTH    = 64;
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 32;
    localparam int OP_W     = 3;
    localparam int STAT_W   = 2;
    localparam int IN_W     = 48;
    localparam int OUT_W    = 48;

    localparam logic [DEPTH-1:0] FREE_INIT =
        (CAPACITY >= DEPTH) ? {DEPTH{1'b1}} : ((64'd1 << CAPACITY) - 64'd1);

    // operation codes
    localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FRONT = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_BACK  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd5;
    localparam logic [OP_W-1:0] OP_READ      = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd3;

    // write requests toward the node memories
    typedef struct packed {
        logic              link_we;
        logic [SLOT_W-1:0] link_addr;
        logic [SLOT_W-1:0] link_data;
        logic              elem_we;
        logic [SLOT_W-1:0] elem_addr;
        logic [VAL_W-1:0]  elem_data;
    } t_ram_wr;

    // lowest set bit of the free map, searched as eight groups of eight
    function automatic logic [SLOT_W-1:0] lowest_free(input logic [DEPTH-1:0] map);
        logic [7:0] grp_any;
        logic [7:0] bits;
        logic [2:0] g;
        logic [2:0] b;
        logic       found_g;
        logic       found_b;
        for (int i = 0; i < 8; i++) begin
            grp_any[i] = |map[i*8 +: 8];
        end
        g = 3'd0;
        found_g = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found_g && grp_any[i]) begin
                g = 3'(i);
                found_g = 1'b1;
            end
        end
        bits = map[{g, 3'b000} +: 8];
        b = 3'd0;
        found_b = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found_b && bits[i]) begin
                b = 3'(i);
                found_b = 1'b1;
            end
        end
        return {g, b};
    endfunction

endpackage

### sv/plst_node_ram.sv
// Element and link memories of the list nodes, one shared read address.
`timescale 1ns / 1ps

module plst_node_ram (
    input  logic                          i_clk,
    input  logic [plst_pkg::SLOT_W-1:0]   i_raddr,
    input  plst_pkg::t_ram_wr             i_wr,
    output logic [plst_pkg::SLOT_W-1:0]   o_link_q,
    output logic [plst_pkg::VAL_W-1:0]    o_elem_q
);

    logic [plst_pkg::SLOT_W-1:0] link_mem [plst_pkg::DEPTH];
    logic [plst_pkg::VAL_W-1:0]  elem_mem [plst_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.link_we) begin
            link_mem[i_wr.link_addr] <= i_wr.link_data;
        end
        o_link_q <= link_mem[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.elem_we) begin
            elem_mem[i_wr.elem_addr] <= i_wr.elem_data;
        end
        o_elem_q <= elem_mem[i_raddr];
    end

endmodule

### sv/positional_list_store.sv
// Top level of the positional list store: sequencer, list registers, result register.
`timescale 1ns / 1ps

// Ordered list of up to 64 signed 32-bit values kept as a linked list in two memories.
// Slave channel s_axis carries one request: op, value, 1-based position. Every request
// yields exactly one result on m_axis: status, read value, length after the operation.
// A request is taken only while the sequencer is idle; one request is in work at a time.
// An out-of-range position, a full insert, an empty delete or an unused op goes straight
// to the result without a walk; an insert or delete at position 1 follows no link.
// A positional operation at position P walks the link memory one node per cycle through
// the single read port of the node memory, to the node before P for an insert or a
// delete and to node P for a read. Back operations walk the whole list. The result
// appears in the same cycle that the next request can be accepted.
// Results sit in an output register; the next request is accepted while a result waits,
// and its own result is held in the sequencer until the output register frees up.
// Reset clears the list (empty, all slots free) and drops any pending result; the node
// memories are not cleared, as only live nodes are ever followed.

module positional_list_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [plst_pkg::IN_W-1:0]    s_axis_tdata,  // op[2:0], value[34:3], position[41:35]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [plst_pkg::OUT_W-1:0]   m_axis_tdata   // status[1:0], read_value[33:2],
                                                        // length[40:34]
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_WALK      = 3'd1;
    localparam logic [2:0] S_DEL_FIX   = 3'd2;
    localparam logic [2:0] S_LINK_NEW  = 3'd3;
    localparam logic [2:0] S_LINK_PREV = 3'd4;
    localparam logic [2:0] S_FINISH    = 3'd5;

    localparam int SW = plst_pkg::SLOT_W;
    localparam int CW = plst_pkg::CNT_W;
    localparam int VW = plst_pkg::VAL_W;

    // control state
    logic [2:0]                   r_state,     n_state;
    logic [SW-1:0]                r_head,      n_head;
    logic [plst_pkg::DEPTH-1:0]   r_free,      n_free;
    logic [CW-1:0]                r_count,     n_count;
    logic                         r_out_valid, n_out_valid;

    // payload
    logic [plst_pkg::OP_W-1:0]    r_op,        n_op;
    logic [VW-1:0]                r_value,     n_value;
    logic                         r_front,     n_front;
    logic [SW-1:0]                r_left,      n_left;
    logic [SW-1:0]                r_cur,       n_cur;
    logic [SW-1:0]                r_victim,    n_victim;
    logic [SW-1:0]                r_new,       n_new;
    logic [SW-1:0]                r_nxt,       n_nxt;
    logic [plst_pkg::STAT_W-1:0]  r_status,    n_status;
    logic [VW-1:0]                r_rdval,     n_rdval;
    logic [plst_pkg::OUT_W-1:0]   r_out_data,  n_out_data;

    logic [SW-1:0]                raddr;
    plst_pkg::t_ram_wr            ram_wr;
    logic [SW-1:0]                link_q;
    logic [VW-1:0]                elem_q;

    logic [plst_pkg::OP_W-1:0]    in_op;
    logic [VW-1:0]                in_value;
    logic [CW-1:0]                in_pos;
    logic [CW-1:0]                epos;
    logic [CW-1:0]                count_inc;
    logic                         is_insert;

    assign in_op    = s_axis_tdata[2:0];
    assign in_value = s_axis_tdata[34:3];
    assign in_pos   = s_axis_tdata[41:35];

    assign count_inc = r_count + 7'd1;
    assign is_insert = (r_op == plst_pkg::OP_INS_FRONT) || (r_op == plst_pkg::OP_INS_BACK) ||
                       (r_op == plst_pkg::OP_INS_POS);

    // effective 1-based position of the request
    always_comb begin
        case (in_op)
            plst_pkg::OP_INS_FRONT: epos = 7'd1;
            plst_pkg::OP_INS_BACK:  epos = count_inc;
            plst_pkg::OP_DEL_FRONT: epos = 7'd1;
            plst_pkg::OP_DEL_BACK:  epos = r_count;
            default:                epos = in_pos;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    plst_node_ram u_node_ram (
        .i_clk    (i_clk),
        .i_raddr  (raddr),
        .i_wr     (ram_wr),
        .o_link_q (link_q),
        .o_elem_q (elem_q)
    );

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_free      = r_free;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_op        = r_op;
        n_value     = r_value;
        n_front     = r_front;
        n_left      = r_left;
        n_cur       = r_cur;
        n_victim    = r_victim;
        n_new       = r_new;
        n_nxt       = r_nxt;
        n_status    = r_status;
        n_rdval     = r_rdval;
        n_out_data  = r_out_data;
        raddr       = r_cur;
        ram_wr      = '0;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                // read port follows the head so a walk can start next cycle
                raddr = r_head;
                if (s_axis_tvalid) begin
                    n_op     = in_op;
                    n_value  = in_value;
                    n_cur    = r_head;
                    n_nxt    = r_head;
                    n_new    = plst_pkg::lowest_free(r_free);
                    n_front  = (epos == 7'd1);
                    n_status = plst_pkg::ST_OK;
                    n_rdval  = '0;
                    n_left   = '0;
                    n_state  = S_FINISH;
                    case (in_op)
                        plst_pkg::OP_INS_FRONT, plst_pkg::OP_INS_BACK,
                        plst_pkg::OP_INS_POS: begin
                            if (epos == 7'd0 || epos > count_inc) begin
                                n_status = plst_pkg::ST_BAD_POS;
                            end else if (r_count >= CW'(plst_pkg::CAPACITY)) begin
                                n_status = plst_pkg::ST_FULL;
                            end else if (epos == 7'd1) begin
                                n_state = S_LINK_NEW;
                            end else begin
                                n_left  = SW'(epos - 7'd2);
                                n_state = S_WALK;
                            end
                        end
                        plst_pkg::OP_DEL_FRONT, plst_pkg::OP_DEL_BACK,
                        plst_pkg::OP_DEL_POS: begin
                            if (in_op != plst_pkg::OP_DEL_POS && r_count == 7'd0) begin
                                n_status = plst_pkg::ST_EMPTY;
                            end else if (epos == 7'd0 || epos > r_count) begin
                                n_status = plst_pkg::ST_BAD_POS;
                            end else begin
                                n_left  = (epos == 7'd1) ? '0 : SW'(epos - 7'd2);
                                n_state = S_WALK;
                            end
                        end
                        plst_pkg::OP_READ: begin
                            if (epos == 7'd0 || epos > r_count) begin
                                n_status = plst_pkg::ST_BAD_POS;
                            end else begin
                                n_left  = SW'(epos - 7'd1);
                                n_state = S_WALK;
                            end
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end

            S_WALK: begin
                // link_q and elem_q hold the node at r_cur
                if (r_left != '0) begin
                    raddr  = link_q;
                    n_cur  = link_q;
                    n_left = r_left - 6'd1;
                end else if (r_op == plst_pkg::OP_READ) begin
                    n_rdval = elem_q;
                    n_state = S_FINISH;
                end else if (is_insert) begin
                    n_nxt   = link_q;
                    n_state = S_LINK_NEW;
                end else if (r_front) begin
                    // drop the head node
                    n_head  = (r_count == 7'd1) ? '0 : link_q;
                    n_free  = r_free | (64'd1 << r_cur);
                    n_count = r_count - 7'd1;
                    n_state = S_FINISH;
                end else begin
                    // fetch the victim's link
                    raddr    = link_q;
                    n_victim = link_q;
                    n_state  = S_DEL_FIX;
                end
            end

            S_DEL_FIX: begin
                ram_wr.link_we   = 1'b1;
                ram_wr.link_addr = r_cur;
                ram_wr.link_data = link_q;
                n_free  = r_free | (64'd1 << r_victim);
                n_count = r_count - 7'd1;
                if (r_count == 7'd1) begin
                    n_head = '0;
                end
                n_state = S_FINISH;
            end

            S_LINK_NEW: begin
                ram_wr.link_we   = 1'b1;
                ram_wr.link_addr = r_new;
                ram_wr.link_data = r_nxt;
                ram_wr.elem_we   = 1'b1;
                ram_wr.elem_addr = r_new;
                ram_wr.elem_data = r_value;
                n_free  = r_free & ~(64'd1 << r_new);
                n_count = count_inc;
                if (r_front) begin
                    n_head  = r_new;
                    n_state = S_FINISH;
                end else begin
                    n_state = S_LINK_PREV;
                end
            end

            S_LINK_PREV: begin
                ram_wr.link_we   = 1'b1;
                ram_wr.link_addr = r_cur;
                ram_wr.link_data = r_new;
                n_state = S_FINISH;
            end

            S_FINISH: begin
                // hold the result until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_count, r_rdval, r_status};
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_free      <= plst_pkg::FREE_INIT;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_value    <= n_value;
        r_front    <= n_front;
        r_left     <= n_left;
        r_cur      <= n_cur;
        r_victim   <= n_victim;
        r_new      <= n_new;
        r_nxt      <= n_nxt;
        r_status   <= n_status;
        r_rdval    <= n_rdval;
        r_out_data <= n_out_data;
    end

endmodule

### tb/positional_list_store_tb.sv
// Self-checking testbench of the positional list store: directed and random list requests.
`timescale 1ns / 1ps

module positional_list_store_tb;

    localparam int N_ITEMS      = 450;
    localparam int FILL_ITEMS   = 80;
    localparam int QUIET_TAIL   = 60;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 100;

    // op code with no meaning, must be ignored
    localparam logic [plst_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    typedef struct packed {
        logic [plst_pkg::CNT_W-1:0]        position;
        logic signed [plst_pkg::VAL_W-1:0] value;
        logic [plst_pkg::OP_W-1:0]         op;
    } t_list_req;

    typedef struct packed {
        logic [plst_pkg::CNT_W-1:0]        length;
        logic signed [plst_pkg::VAL_W-1:0] read_value;
        logic [plst_pkg::STAT_W-1:0]       status;
    } t_list_res;

    logic                       i_clk         = 1'b0;
    logic                       i_rst_n       = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    logic [plst_pkg::IN_W-1:0]  s_axis_tdata  = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    logic [plst_pkg::OUT_W-1:0] m_axis_tdata;

    logic signed [plst_pkg::VAL_W-1:0] model_list[$];   // list contents, head first
    t_list_req                         op_backlog[$];
    t_list_res                         pending_replies[$];
    t_list_req                         on_bus;

    int n_total     = 0;
    int n_replied   = 0;
    int n_mismatch  = 0;
    int gap_left    = 0;
    int stall_left  = 0;
    int hold_left   = 0;
    int idle_cycles = 0;
    bit hold_done   = 1'b0;

    positional_list_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // op[2:0], value[34:3], position[41:35]
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // status[1:0], read_value[33:2], length[40:34]
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the list and return the reply it should produce.
    function automatic t_list_res apply_list_op(t_list_req rq);
        t_list_res rs;
        int        n;
        int        at;
        rs = '0;
        rs.status = plst_pkg::ST_OK;
        n = model_list.size();
        at = int'(rq.position);
        case (rq.op)
            plst_pkg::OP_INS_FRONT, plst_pkg::OP_INS_BACK, plst_pkg::OP_INS_POS: begin
                if (rq.op == plst_pkg::OP_INS_FRONT)
                    at = 1;
                else if (rq.op == plst_pkg::OP_INS_BACK)
                    at = n + 1;
                if (at < 1 || at > n + 1)
                    rs.status = plst_pkg::ST_BAD_POS;
                else if (n >= plst_pkg::CAPACITY)
                    rs.status = plst_pkg::ST_FULL;
                else
                    model_list.insert(at - 1, rq.value);
            end
            plst_pkg::OP_DEL_FRONT, plst_pkg::OP_DEL_BACK: begin
                if (n == 0)
                    rs.status = plst_pkg::ST_EMPTY;
                else if (rq.op == plst_pkg::OP_DEL_FRONT)
                    model_list.delete(0);
                else
                    model_list.delete(n - 1);
            end
            plst_pkg::OP_DEL_POS: begin
                if (at < 1 || at > n)
                    rs.status = plst_pkg::ST_BAD_POS;
                else
                    model_list.delete(at - 1);
            end
            plst_pkg::OP_READ: begin
                if (at < 1 || at > n)
                    rs.status = plst_pkg::ST_BAD_POS;
                else
                    rs.read_value = model_list[at - 1];
            end
            default: ;
        endcase
        rs.length = plst_pkg::CNT_W'(model_list.size());
        return rs;
    endfunction

    // Queue a request; the list is advanced too so later picks know its length.
    function automatic void queue_op(logic [plst_pkg::OP_W-1:0] op,
                                     logic signed [plst_pkg::VAL_W-1:0] value,
                                     int position);
        t_list_req rq;
        t_list_res unused_res;
        rq.op       = op;
        rq.value    = value;
        rq.position = plst_pkg::CNT_W'(position);
        op_backlog.push_back(rq);
        unused_res = apply_list_op(rq);
    endfunction

    function automatic void queue_random_op(int mode);
        int                                n;
        int                                r;
        int                                ins_pct;
        int                                del_pct;
        int                                pos;
        logic [plst_pkg::OP_W-1:0]         op;
        logic signed [plst_pkg::VAL_W-1:0] v;
        n = model_list.size();
        case (mode)
            MODE_GROW:   begin ins_pct = 90; del_pct = 3;  end
            MODE_SHRINK: begin ins_pct = 15; del_pct = 70; end
            default:     begin ins_pct = 45; del_pct = 35; end
        endcase
        case ($urandom_range(0, 7))
            0:       v = 32'sh7fff_ffff;
            1:       v = 32'sh8000_0000;
            2:       v = '0;
            default: v = $urandom;
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            op  = plst_pkg::OP_INS_FRONT + plst_pkg::OP_W'($urandom_range(0, 2));
            pos = $urandom_range(1, n + 1);
        end else if (r < ins_pct + del_pct) begin
            op  = plst_pkg::OP_DEL_FRONT + plst_pkg::OP_W'($urandom_range(0, 2));
            pos = (n == 0) ? 1 : $urandom_range(1, n);
        end else if (r < 95) begin
            op  = plst_pkg::OP_READ;
            pos = (n == 0) ? 1 : $urandom_range(1, n);
        end else begin
            // noise: any op code, any position
            op  = plst_pkg::OP_W'($urandom_range(0, 7));
            pos = $urandom_range(0, 127);
        end
        queue_op(op, v, pos);
    endfunction

    initial begin
        int mode;
        int seg_len;
        // empty list corner cases
        queue_op(plst_pkg::OP_DEL_FRONT, 32'sd5, 1);
        queue_op(plst_pkg::OP_DEL_BACK,  32'sd5, 1);
        queue_op(plst_pkg::OP_DEL_POS,   32'sd0, 1);
        queue_op(plst_pkg::OP_READ,      32'sd0, 1);
        queue_op(plst_pkg::OP_INS_POS,   32'sd9, 0);
        queue_op(plst_pkg::OP_INS_POS,   32'sd9, 2);
        // build max, 0, min, -1
        queue_op(plst_pkg::OP_INS_FRONT, 32'sh7fff_ffff, 0);
        queue_op(plst_pkg::OP_INS_BACK,  32'sh8000_0000, 127);
        queue_op(plst_pkg::OP_INS_POS,   32'sd0, 2);
        queue_op(plst_pkg::OP_INS_POS,   -32'sd1, 4);
        queue_op(plst_pkg::OP_INS_POS,   32'sd3, 6);
        for (int i = 1; i <= 5; i++)
            queue_op(plst_pkg::OP_READ, 32'sd0, i);
        queue_op(plst_pkg::OP_READ,      32'sd0, 127);
        queue_op(OP_UNUSED,              -32'sd1, 127);
        queue_op(plst_pkg::OP_DEL_POS,   32'sd0, 0);
        queue_op(plst_pkg::OP_DEL_POS,   32'sd0, 2);
        queue_op(plst_pkg::OP_DEL_BACK,  32'sd0, 0);
        queue_op(plst_pkg::OP_DEL_FRONT, 32'sd0, 0);
        queue_op(plst_pkg::OP_DEL_POS,   32'sd0, 1);

        // fill past capacity first, then alternate grow, shrink and mixed stretches
        for (int i = 0; i < FILL_ITEMS; i++)
            queue_random_op(MODE_GROW);
        while (op_backlog.size() < N_ITEMS) begin
            mode    = $urandom_range(MODE_GROW, MODE_MIXED);
            seg_len = $urandom_range(30, 90);
            for (int i = 0; i < seg_len && op_backlog.size() < N_ITEMS; i++)
                queue_random_op(mode);
        end
        n_total = op_backlog.size();
        model_list.delete();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_replied < n_total) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && pending_replies.size() == 0)
            $display("positional_list_store regression: pass");
        else
            $display("positional_list_store regression: fail");
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        t_list_req rq;
        logic      next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left = 0;
        end else begin
            next_valid = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                pending_replies.push_back(apply_list_op(on_bus));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                end else if (op_backlog.size() != 0) begin
                    if (op_backlog.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                        // idle the bus for a randomly drawn gap before the next request
                        gap_left = $urandom_range(0, 9);
                    end else begin
                        rq = op_backlog.pop_front();
                        on_bus       <= rq;
                        s_axis_tdata <= {{(plst_pkg::IN_W - $bits(t_list_req)){1'b0}}, rq};
                        next_valid = 1'b1;
                    end
                end
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // reply monitor and receiver back-pressure
    always @(posedge i_clk) begin
        t_list_res got;
        t_list_res want;
        logic      next_ready;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[$bits(t_list_res)-1:0];
                n_replied = n_replied + 1;
                if (pending_replies.size() == 0) begin
                    n_mismatch = n_mismatch + 1;
                    if (n_mismatch <= 10)
                        $display("reply %0d with no request pending: status %0d value %0d len %0d",
                                 n_replied, got.status, got.read_value, got.length);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.status !== want.status || got.read_value !== want.read_value ||
                        got.length !== want.length) begin
                        n_mismatch = n_mismatch + 1;
                        if (n_mismatch <= 10)
                            $display("reply %0d: expected status %0d value %0d len %0d, %s%0d %0d %0d",
                                     n_replied, want.status, want.read_value, want.length,
                                     "got ", got.status, got.read_value, got.length);
                    end
                end
            end

            // one long hold-off mid run so the block backs up into its input
            if (!hold_done && n_replied >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left  = hold_left - 1;
                next_ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
                next_ready = 1'b0;
            end else if (n_replied + QUIET_TAIL < n_total && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 9);
                next_ready = 1'b0;
            end else begin
                next_ready = 1'b1;
            end
            m_axis_tready <= next_ready;
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("positional_list_store regression: fail");
            $finish;
        end
    end

endmodule

### positional_list_store.f
sv/plst_pkg.sv
sv/plst_node_ram.sv
sv/positional_list_store.sv
tb/positional_list_store_tb.sv
